/* hdl/fpc_pkg.sv */
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the framed packet checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

	localparam int unsigned POS_W     = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned OUT_W     = 40;

	typedef enum logic [2:0] {
		CODE_OK     = 3'd0,
		CODE_FRAME  = 3'd1,
		CODE_PACKET = 3'd2,
		CODE_HEADER = 3'd3,
		CODE_FOOTER = 3'd4
	} check_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER = 2'd0,
		REG_FOOTER = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} fpc_item_t;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [7:0]  cmd_byte;
		logic [15:0] frame_size;
		check_code_t check_code;
	} fpc_result_t;

endpackage

`default_nettype wire

/* hdl/fpc_parser.sv */
// ----------------------------------------------------------------------------
// fpc_parser
// Per-packet state, pattern registers and the final verdict for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_parser
	import fpc_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = 255,
	parameter int unsigned MARKER_BYTES     = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 advance,
	input  wire fpc_item_t            item,
	output fpc_result_t               result
);

	localparam int unsigned FOOT_W = 8 * MARKER_BYTES;
	localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(MARKER_BYTES);
	localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(MARKER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_CMD    = POS_W'(MARKER_BYTES + 2);
	localparam logic [POS_W-1:0] POS_STAT   = POS_W'(MARKER_BYTES + 4);
	localparam logic [POS_W-1:0] MIN_BYTES  = POS_W'(MARKER_BYTES + 2);
	localparam logic [POS_W-1:0] MAX_BYTES  = POS_W'(MAX_PACKET_BYTES);
	localparam logic [16:0]      OVERHEAD   = 17'(2 * MARKER_BYTES + 2);

	logic [CFG_W-1:0] header_q;
	logic [CFG_W-1:0] footer_q;
	logic [POS_W-1:0] pos_q;
	logic             hdr_ok_q;
	logic [15:0]      len_q;
	logic [7:0]       cmd_q;
	logic [7:0]       status_q;
	logic [31:0]      tail_q;

	logic [POS_W-1:0] pos_n;
	logic             hdr_ok_n;
	logic [15:0]      len_n;
	logic [7:0]       cmd_n;
	logic [7:0]       status_n;
	logic [31:0]      tail_n;
	logic [CFG_W-1:0] hdr_shift;
	logic [16:0]      expected;
	check_code_t      code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			footer_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEADER) begin
				header_q <= cfg_data;
			end else if (cfg_index == REG_FOOTER) begin
				footer_q <= cfg_data;
			end
		end
	end

	// pick the expected header byte for the current position
	assign hdr_shift = header_q >> {pos_q[1:0], 3'b000};

	always_comb begin
		hdr_ok_n = hdr_ok_q;
		len_n    = len_q;
		cmd_n    = cmd_q;
		status_n = status_q;
		if (pos_q < POS_LEN_LO) begin
			if (hdr_shift[7:0] != item.data_byte) begin
				hdr_ok_n = 1'b0;
			end
		end else if (pos_q == POS_LEN_LO) begin
			len_n[7:0] = item.data_byte;
		end else if (pos_q == POS_LEN_HI) begin
			len_n[15:8] = item.data_byte;
		end else if (pos_q == POS_CMD) begin
			cmd_n = item.data_byte;
		end else if (pos_q == POS_STAT) begin
			status_n = item.data_byte;
		end
		tail_n = {item.data_byte, tail_q[31:8]};
		pos_n  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	end

	assign expected = {1'b0, len_n} + OVERHEAD;

	always_comb begin
		if (pos_n < MIN_BYTES || pos_n > MAX_BYTES) begin
			code = CODE_PACKET;
		end else if (len_n == 16'd0) begin
			code = CODE_FRAME;
		end else if ({8'd0, pos_n} != expected) begin
			code = CODE_PACKET;
		end else if (!hdr_ok_n) begin
			code = CODE_HEADER;
		end else if (tail_n[31 -: FOOT_W] != footer_q[FOOT_W-1:0]) begin
			code = CODE_FOOTER;
		end else if (len_n < 16'd4) begin
			code = CODE_FRAME;
		end else begin
			code = CODE_OK;
		end
	end

	always_comb begin
		result.check_code  = code;
		result.frame_size  = len_n;
		result.cmd_byte    = (code == CODE_OK) ? cmd_n : 8'd0;
		result.status_byte = (code == CODE_OK) ? status_n : 8'd0;
	end

	// clear the packet state after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr_ok_q <= 1'b1;
			len_q    <= '0;
			cmd_q    <= '0;
			status_q <= '0;
			tail_q   <= '0;
		end else if (advance) begin
			if (item.last_byte) begin
				pos_q    <= '0;
				hdr_ok_q <= 1'b1;
				len_q    <= '0;
				cmd_q    <= '0;
				status_q <= '0;
				tail_q   <= '0;
			end else begin
				pos_q    <= pos_n;
				hdr_ok_q <= hdr_ok_n;
				len_q    <= len_n;
				cmd_q    <= cmd_n;
				status_q <= status_n;
				tail_q   <= tail_n;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/framed_packet_checker.sv */
// ----------------------------------------------------------------------------
// framed_packet_checker
// Byte-stream checker for header / length / payload / footer packets.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock on the slave stream, tlast on the final byte,
// and delivers one verdict per packet on the master stream. Each byte passes an
// input register and then the parser, whose per-byte logic is combinational,
// so the block sustains one byte per cycle unless a final byte is held; the
// verdict of a final byte in the input register is loaded into the result
// register, which drives the master stream. While the result register
// waits for the master side, non-final bytes keep flowing; only a final byte
// holds in the input register until the result register frees up. Write the
// header and footer patterns only while the block is idle.
`default_nettype none

module framed_packet_checker
	import fpc_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = 255,
	parameter int unsigned MARKER_BYTES     = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  wire logic                 s_axis_tlast,  // last_byte
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [2:0] check_code, [18:3] frame_size, [26:19] cmd_byte,
	// [34:27] status_byte, [39:35] zero
	output logic [OUT_W-1:0]          m_axis_tdata
);

	logic        valid_s1;
	fpc_item_t   item_s1;
	logic        advance;
	logic        load_out;
	fpc_result_t result;
	fpc_result_t out_q;
	logic        out_valid_q;

	assign load_out      = valid_s1 && item_s1.last_byte && (!out_valid_q || m_axis_tready);
	assign advance       = valid_s1 && (!item_s1.last_byte || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte <= s_axis_tdata;
			item_s1.last_byte <= s_axis_tlast;
		end
	end

	fpc_parser #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES),
		.MARKER_BYTES    (MARKER_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (advance),
		.item     (item_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - $bits(fpc_result_t))'(0), out_q};

endmodule

`default_nettype wire

/* hdl/fpc_checker.sv */
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level assertions for the framed packet checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker
	import fpc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	// a stalled verdict holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("verdict changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] == CODE_OK || m_axis_tdata[2:0] == CODE_FRAME
			|| m_axis_tdata[2:0] == CODE_PACKET || m_axis_tdata[2:0] == CODE_HEADER
			|| m_axis_tdata[2:0] == CODE_FOOTER)
		else $error("check code out of range");

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != CODE_OK |-> m_axis_tdata[34:19] == 16'd0)
		else $error("command or status shown on a failed packet");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == CODE_OK |-> m_axis_tdata[18:3] >= 16'd4)
		else $error("passed packet with short payload");

endmodule

bind framed_packet_checker fpc_checker u_fpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

/* bench/tb_framed_packet_checker.sv */
// ----------------------------------------------------------------------------
// tb_framed_packet_checker
// Self-checking bench for the framed packet checker.
// ----------------------------------------------------------------------------
// A short table of bytes runs first, with the verdicts of the error cases
// written out. Then the stimulus runs in phases, each with its own header and
// footer patterns. Most packets are well formed with random payloads; the rest
// corrupt one marker byte, break the size, cut the packet short or send
// noise. A local byte-level parser predicts the other verdicts, and each verdict
// taken from the master stream is compared field by field with the oldest
// prediction. Both streams idle at random, and one phase holds the master
// side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------

module tb_framed_packet_checker;
	import fpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MB          = 4;
	localparam int MAXB        = 255;
	localparam int RES_W       = $bits(fpc_result_t);
	localparam int PHASE_BYTES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS    = 21;

	typedef struct {
		logic [7:0]  data;
		bit          last;
		bit          typed;
		check_code_t code;
		logic [15:0] size;
	} dir_row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               s_valid   = 1'b0;
	logic [7:0]         s_data    = '0;
	logic               s_last    = 1'b0;
	logic               m_ready   = 1'b0;
	logic               s_ready;
	logic               m_valid;
	logic [OUT_W-1:0]   m_data;

	// local copy of the parser state and the pattern registers
	logic [8:0]  pos      = '0;
	bit          hdr_ok   = 1'b1;
	logic [15:0] len_v    = '0;
	logic [7:0]  cmd_v    = '0;
	logic [7:0]  stat_v   = '0;
	logic [31:0] tail_v   = '0;
	logic [31:0] hdr_pat  = '0;
	logic [31:0] ftr_pat  = '0;

	fpc_result_t verdict_q[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	bit          tx_gaps    = 1'b1;
	bit          rx_gaps    = 1'b1;
	bit          hold_req   = 1'b0;
	dir_row_t    dir_table [DIR_ROWS];

	framed_packet_checker #(
		.MAX_PACKET_BYTES(MAXB),
		.MARKER_BYTES    (MB)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.s_axis_tlast (s_last),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_framed_packet_checker: errors");
		$finish;
	end

	// Advance the parser by one byte; a final byte yields the verdict.
	task automatic parse_byte(input logic [7:0] b, input bit last, output bit has,
			output fpc_result_t v);
		int          idx;
		int          count;
		check_code_t code;
		logic [31:0] mask;
		logic [31:0] tail;
		idx = pos;
		has = 1'b0;
		v   = '0;
		if (idx < MB) begin
			if (hdr_pat[8*idx +: 8] != b)
				hdr_ok = 1'b0;
		end else if (idx == MB) begin
			len_v[7:0] = b;
		end else if (idx == MB + 1) begin
			len_v[15:8] = b;
		end else if (idx == MB + 2) begin
			cmd_v = b;
		end else if (idx == MB + 4) begin
			stat_v = b;
		end
		tail_v = {b, tail_v[31:8]};
		if (pos != 9'd511)
			pos = pos + 9'd1;
		if (last) begin
			count = pos;
			mask  = 32'hFFFF_FFFF >> (32 - 8*MB);
			tail  = tail_v >> (32 - 8*MB);
			if (count < MB + 2 || count > MAXB)
				code = CODE_PACKET;
			else if (len_v == 16'd0)
				code = CODE_FRAME;
			else if (count != 2*MB + 2 + int'(len_v))
				code = CODE_PACKET;
			else if (!hdr_ok)
				code = CODE_HEADER;
			else if ((tail & mask) != (ftr_pat & mask))
				code = CODE_FOOTER;
			else if (len_v < 16'd4)
				code = CODE_FRAME;
			else
				code = CODE_OK;
			v.check_code  = code;
			v.frame_size  = len_v;
			v.cmd_byte    = (code == CODE_OK) ? cmd_v : 8'h00;
			v.status_byte = (code == CODE_OK) ? stat_v : 8'h00;
			has    = 1'b1;
			pos    = '0;
			hdr_ok = 1'b1;
			len_v  = '0;
			cmd_v  = '0;
			stat_v = '0;
			tail_v = '0;
		end
	endtask

	// Offer one byte, hold it until taken, then record the predicted verdict.
	task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
			input fpc_result_t typed_res);
		int          gap;
		bit          has;
		fpc_result_t v;
		gap = tx_gaps ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= b;
		s_last  <= last;
		do @(posedge clk); while (!s_ready);
		parse_byte(b, last, has, v);
		if (has)
			verdict_q.push_back(typed ? typed_res : v);
		bytes_sent++;
	endtask

	// Build a packet of n bytes around the current patterns; flip corrupts
	// one bit of byte flip when it is not negative.
	task automatic send_packet(input int n, input logic [15:0] len, input int flip);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if (i < MB)
				b = hdr_pat[8*i +: 8];
			else if (i == MB)
				b = len[7:0];
			else if (i == MB + 1)
				b = len[15:8];
			else if (i >= n - MB)
				b = ftr_pat[8*(i - (n - MB)) +: 8];
			else
				b = 8'($urandom);
			if (i == flip)
				b = b ^ (8'h01 << $urandom_range(0, 7));
			send_byte(b, i == n - 1, 1'b0, '0);
		end
	endtask

	task automatic write_patterns(input logic [31:0] h, input logic [31:0] f);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEADER;
		cfg_data  <= h;
		@(posedge clk);
		hdr_pat = h;
		cfg_index <= REG_FOOTER;
		cfg_data  <= f;
		@(posedge clk);
		ftr_pat = f;
		cfg_we <= 1'b0;
	endtask

	// Drop the request and wait for every pending verdict, plus the pipeline.
	task automatic wait_idle();
		s_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic take_verdict(input logic [OUT_W-1:0] raw);
		fpc_result_t got;
		fpc_result_t want;
		got = raw[RES_W-1:0];
		if (verdict_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected verdict: tdata %h", raw);
		end else begin
			want = verdict_q.pop_front();
			if (got.check_code != want.check_code || got.frame_size != want.frame_size ||
					got.cmd_byte != want.cmd_byte || got.status_byte != want.status_byte ||
					raw[OUT_W-1:RES_W] != '0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"verdict mismatch: expected code %0d size %h cmd %h status %h,",
						" got code %0d size %h cmd %h status %h pad %h"},
						want.check_code, want.frame_size, want.cmd_byte, want.status_byte,
						got.check_code, got.frame_size, got.cmd_byte, got.status_byte,
						raw[OUT_W-1:RES_W]);
			end
		end
	endtask

	// master side: random ready gaps, one long hold-off on request
	initial begin : result_sink
		int gap;
		forever begin
			if (hold_req) begin
				gap      = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = rx_gaps ? $urandom_range(0, 3) : 0;
			end
			if (gap != 0) begin
				m_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_ready <= 1'b1;
			do @(posedge clk); while (!m_valid);
			take_verdict(m_data);
		end
	end

	initial begin : stimulus
		fpc_result_t typed_res;
		logic [31:0] h;
		logic [31:0] f;
		logic [15:0] len;
		int          kind;
		int          n;
		int          flip;
		int          start;

		dir_table = '{
			// a lone final byte right after reset
			'{8'h00, 1'b1, 1'b1, CODE_PACKET, 16'h0000},
			// shortest legal size with a zero length
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b1, 1'b1, CODE_FRAME,  16'h0000},
			// good packet, shortest payload
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h04, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'hFF, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h12, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h80, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h01, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b0, 1'b0, CODE_OK,     16'h0000},
			'{8'h00, 1'b1, 1'b0, CODE_OK,     16'h0000}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			typed_res             = '0;
			typed_res.check_code  = dir_table[i].code;
			typed_res.frame_size  = dir_table[i].size;
			send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed, typed_res);
		end
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					h = 32'hFFFF_FFFF;
					f = 32'h0000_0000;
				end
				1: begin
					h = 32'h0000_0000;
					f = 32'hFFFF_FFFF;
				end
				4: begin
					h = $urandom;
					f = h;
				end
				default: begin
					h = $urandom;
					f = $urandom;
				end
			endcase
			tx_gaps = (phase != 2);
			rx_gaps = (phase != 2);
			write_patterns(h, f);
			if (phase == 1)
				hold_req = 1'b1;
			if (phase == 3)
				// count saturates past 511
				send_packet(520, 16'h0100, -1);
			if (phase == 4) begin
				// largest legal packet, then one byte over
				send_packet(MAXB, 16'(MAXB - 2*MB - 2), -1);
				send_packet(MAXB + 1, 16'(MAXB - 2*MB - 1), -1);
			end
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				kind = $urandom_range(0, 99);
				len  = 16'($urandom_range(4, 16));
				n    = 2*MB + 2 + len;
				flip = -1;
				if (kind < 55) begin
				end else if (kind < 63) begin
					len = 16'($urandom_range(0, 3));
					n   = 2*MB + 2 + len;
				end else if (kind < 70) begin
					flip = $urandom_range(0, MB - 1);
				end else if (kind < 77) begin
					flip = n - 1 - $urandom_range(0, MB - 1);
				end else if (kind < 84) begin
					if ($urandom_range(0, 1))
						n = n + $urandom_range(1, 3);
					else
						n = n - $urandom_range(1, 3);
				end else if (kind < 89) begin
					len = 16'($urandom);
				end else if (kind < 93) begin
					n = $urandom_range(1, MB + 1);
				end else if (kind < 95) begin
					len = 16'($urandom_range(MAXB - 2*MB - 42, MAXB - 2*MB - 2));
					n   = 2*MB + 2 + len;
				end else if (kind < 97) begin
					n = $urandom_range(MAXB + 1, MAXB + 40);
				end
				if (kind >= 97) begin
					// noise: random bytes, random frame ends
					n = $urandom_range(1, 40);
					for (int i = 0; i < n; i++)
						send_byte(8'($urandom),
							(i == n - 1) || ($urandom_range(0, 15) == 0), 1'b0, '0);
				end else begin
					send_packet(n, len, flip);
				end
			end
			wait_idle();
		end

		repeat (6) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("tb_framed_packet_checker: clean");
		else
			$display("tb_framed_packet_checker: errors");
		$finish;
	end

endmodule
